// File: src/ipv4p_pkg.sv
// ============================================================================
// ipv4p_pkg
// Shared types and constants for the dotted-decimal IPv4 text parser.
// ============================================================================
package ipv4p_pkg;

    // Shortest text, in characters, that is rejected: any text of this
    // length or longer gives an invalid result.
    localparam logic [4:0] MAX_TEXT_BYTES = 5'd16;

    // Field value limits (the magnitude saturates one above the largest byte).
    localparam logic [8:0] FIELD_MAX   = 9'd255;
    localparam logic [8:0] FIELD_SAT   = 9'd256;
    localparam logic [2:0] FIELD_COUNT = 3'd4;
    localparam logic [4:0] LENGTH_SAT  = 5'd31;

    // Characters that the parser recognizes.
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // One input item: a character or a terminator.
    typedef struct packed {
        logic       end_of_text;
        logic [7:0] text_char;
    } item_t;

    // One result item.
    typedef struct packed {
        logic        addr_valid;
        logic [31:0] address;
    } result_t;

endpackage

// File: src/ipv4p_in_reg.sv
// ============================================================================
// ipv4p_in_reg
// Input register: holds one accepted request until the parser consumes it.
// ============================================================================
module ipv4p_in_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  ipv4p_pkg::item_t     s_item,
    input  logic                 consume,
    output logic                 item_valid,
    output ipv4p_pkg::item_t     item
);

    logic             valid_reg;
    logic             valid_next;
    ipv4p_pkg::item_t item_reg;

    // The register takes a new request when it is empty or drains this cycle.
    assign s_tready = !valid_reg || consume;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: src/ipv4p_parser.sv
// ============================================================================
// ipv4p_parser
// Per-character parse state and its update for each consumed item; a terminator closes
// the text and produces the result.
// ============================================================================
module ipv4p_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  ipv4p_pkg::item_t     item,
    output ipv4p_pkg::result_t   result
);

    logic [8:0]  val_reg,      val_next;
    logic        minus_reg,    minus_next;
    logic        nonempty_reg, nonempty_next;
    logic [2:0]  done_reg,     done_next;
    logic        err_reg,      err_next;
    logic [31:0] shift_reg,    shift_next;
    logic [4:0]  len_reg,      len_next;

    logic        close_err;
    logic [2:0]  close_done;
    logic [31:0] close_shift;
    logic        fin_err;
    logic [2:0]  fin_done;
    logic [31:0] fin_shift;
    logic        fin_ok;
    logic        is_digit;
    logic [11:0] times_ten;

    // Effect of closing the current field.
    always_comb begin
        close_err = err_reg || (val_reg > ipv4p_pkg::FIELD_MAX)
                    || (minus_reg && (val_reg != 9'd0))
                    || (done_reg >= ipv4p_pkg::FIELD_COUNT);
        if (done_reg >= ipv4p_pkg::FIELD_COUNT) begin
            close_done  = done_reg;
            close_shift = shift_reg;
        end else begin
            close_done  = done_reg + 3'd1;
            close_shift = {shift_reg[23:0], val_reg[7:0]};
        end
    end

    // Shift-and-add multiply by ten plus the new digit.
    assign is_digit  = (item.text_char >= ipv4p_pkg::CHAR_ZERO)
                       && (item.text_char <= ipv4p_pkg::CHAR_NINE);
    assign times_ten = {val_reg, 3'b000} + {2'b00, val_reg, 1'b0}
                       + {8'd0, item.text_char[3:0]};

    // A trailing non-empty field is closed by the terminator.
    always_comb begin
        if (nonempty_reg) begin
            fin_err   = close_err;
            fin_done  = close_done;
            fin_shift = close_shift;
        end else begin
            fin_err   = err_reg;
            fin_done  = done_reg;
            fin_shift = shift_reg;
        end
        fin_ok = !fin_err && (fin_done == ipv4p_pkg::FIELD_COUNT)
                 && (len_reg < ipv4p_pkg::MAX_TEXT_BYTES);
        result.addr_valid = fin_ok;
        result.address    = fin_ok ? fin_shift : 32'd0;
    end

    // Next state for a character or a terminator.
    always_comb begin
        val_next      = val_reg;
        minus_next    = minus_reg;
        nonempty_next = nonempty_reg;
        done_next     = done_reg;
        err_next      = err_reg;
        shift_next    = shift_reg;
        len_next      = len_reg;
        if (step) begin
            if (item.end_of_text) begin
                // Back to the reset state for the next text.
                val_next      = 9'd0;
                minus_next    = 1'b0;
                nonempty_next = 1'b0;
                done_next     = 3'd0;
                err_next      = 1'b0;
                shift_next    = 32'd0;
                len_next      = 5'd0;
            end else begin
                if (len_reg < ipv4p_pkg::LENGTH_SAT) begin
                    len_next = len_reg + 5'd1;
                end
                if (item.text_char == ipv4p_pkg::CHAR_DOT) begin
                    if (!nonempty_reg) begin
                        err_next = 1'b1;
                    end else begin
                        err_next      = close_err;
                        done_next     = close_done;
                        shift_next    = close_shift;
                        val_next      = 9'd0;
                        minus_next    = 1'b0;
                        nonempty_next = 1'b0;
                    end
                end else if (item.text_char == ipv4p_pkg::CHAR_MINUS) begin
                    // A minus sign is legal only as the first character of a field.
                    err_next      = err_reg || nonempty_reg;
                    minus_next    = 1'b1;
                    nonempty_next = 1'b1;
                end else if (is_digit) begin
                    if (times_ten > {3'd0, ipv4p_pkg::FIELD_SAT}) begin
                        val_next = ipv4p_pkg::FIELD_SAT;
                    end else begin
                        val_next = times_ten[8:0];
                    end
                    nonempty_next = 1'b1;
                end else begin
                    err_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg      <= 9'd0;
            minus_reg    <= 1'b0;
            nonempty_reg <= 1'b0;
            done_reg     <= 3'd0;
            err_reg      <= 1'b0;
            shift_reg    <= 32'd0;
            len_reg      <= 5'd0;
        end else begin
            val_reg      <= val_next;
            minus_reg    <= minus_next;
            nonempty_reg <= nonempty_next;
            done_reg     <= done_next;
            err_reg      <= err_next;
            shift_reg    <= shift_next;
            len_reg      <= len_next;
        end
    end

endmodule

// File: src/ipv4p_out_reg.sv
// ============================================================================
// ipv4p_out_reg
// Result register on the master side; holds a result until it is taken.
// ============================================================================
module ipv4p_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  ipv4p_pkg::result_t   result,
    output logic                 free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output ipv4p_pkg::result_t   m_result
);

    logic               valid_reg;
    logic               valid_next;
    ipv4p_pkg::result_t result_reg;

    // Free when empty or when the held result leaves this cycle.
    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_result = result_reg;

endmodule

// File: src/ipv4_text_to_address_core.sv
// ============================================================================
// ipv4_text_to_address_core
// Dotted-decimal IPv4 text parser: one character per request, a terminator
// request yields a valid flag and the 32-bit address.
// ============================================================================
//
//  Channel  Direction  tdata                  tuser
//  s_       in         [7:0] text_char        [0] end_of_text
//  m_       out        [31:0] address         [0] addr_valid
//
//  One request is accepted per cycle while no terminator waits in the input
//  register; a character is held there and updates the parse state when it
//  leaves it. A result is loaded into the result register when its
//  terminator leaves the input register.
//  A terminator waits in the input register while the result register is
//  full; characters pass regardless of m_tready.
//  aresetn clears the parse state and both valid flags.
//
module ipv4_text_to_address_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_char
    input  logic [0:0]  s_tuser,   // [0] end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] address
    output logic [0:0]  m_tuser    // [0] addr_valid
);

    ipv4p_pkg::item_t   s_item;
    ipv4p_pkg::item_t   item;
    ipv4p_pkg::result_t result;
    ipv4p_pkg::result_t m_result;
    logic               item_valid;
    logic               out_free;
    logic               consume;

    assign s_item.text_char   = s_tdata;
    assign s_item.end_of_text = s_tuser[0];

    // A terminator needs room in the result register; characters never wait.
    assign consume = item_valid && (!item.end_of_text || out_free);

    ipv4p_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .consume    (consume),
        .item_valid (item_valid),
        .item       (item)
    );

    ipv4p_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (consume),
        .item    (item),
        .result  (result)
    );

    ipv4p_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (consume && item.end_of_text),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    assign m_tdata    = m_result.address;
    assign m_tuser[0] = m_result.addr_valid;

endmodule

// File: src/ipv4p_checker.sv
// ============================================================================
// ipv4p_checker
// Port-level checks on the parser's result channel.
// ============================================================================
module ipv4p_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // An invalid result carries a zero address.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0)
        else $error("invalid result with nonzero address");

    // Reset empties the result register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present after reset");

    // Reset empties the input register, so it is ready right after.
    assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

endmodule

bind ipv4_text_to_address_core ipv4p_checker u_ipv4p_checker (.*);
